>>> rtl/smc_pkg.sv
package smc_pkg;

	// fixed point format and tanh table geometry
	localparam int FRAC_BITS     = 16;
	localparam int TANH_ENTRIES  = 64;
	localparam int TANH_IDX_BITS = $clog2(TANH_ENTRIES);
	localparam int TANH_SHIFT    = FRAC_BITS + 2 - TANH_IDX_BITS;
	localparam int TANH_BITS     = FRAC_BITS + 1;
	localparam int WIDE_BITS     = 30;

	localparam logic [31:0] FX_ONE     = 32'h1 << FRAC_BITS;
	localparam logic [32:0] TANH_LIMIT = 33'h4 << FRAC_BITS;

	localparam logic signed [63:0] SAT_HI = 64'sh7fffffff;
	localparam logic signed [63:0] SAT_LO = -64'sh80000000;

	// configuration port
	localparam int CFG_BITS       = 31;
	localparam int CFG_INDEX_BITS = 3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FILTER_WEIGHT    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_STEP_TIME    = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SURFACE_SLOPE    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DRIVE_GAIN       = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_BOUND_WIDTH  = 3'd4;

	localparam int UPC_BITS = 5;

	typedef struct packed {
		logic signed [31:0] target_value;
		logic signed [31:0] measured_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] control_drive;
		logic signed [31:0] filtered_distance;
		logic signed [31:0] error_value;
		logic signed [31:0] filtered_error_rate;
		logic signed [31:0] sliding_surface;
	} out_item_t;

	typedef struct packed {
		logic [16:0]         filter_weight;
		logic [CFG_BITS-1:0] inverse_step_time;
		logic [CFG_BITS-1:0] surface_slope;
		logic [CFG_BITS-1:0] drive_gain;
		logic [CFG_BITS-1:0] inverse_boundary_width;
	} cfg_t;

	// datapath operand sources and destinations
	typedef enum logic [3:0] {
		S_TGT, S_MEAS, S_DIST, S_ERR, S_PERR, S_RATE,
		S_SURF, S_TMP, S_T0, S_TH, S_FRAC, S_PROD
	} src_t;

	// multiplier coefficient side
	typedef enum logic [2:0] {
		MA_ALPHA, MA_ONEMA, MA_INVDT, MA_SLOPE, MA_GAIN, MA_INVPHI, MA_DIFF
	} ma_t;

	typedef enum logic [2:0] {
		OP_NOP, OP_ADD, OP_SUB, OP_PASS, OP_NEG, OP_PREP, OP_INTERP, OP_SATONE
	} op_t;

	typedef enum logic [1:0] {
		J_NEXT, J_GO, J_BIG
	} jmp_t;

	typedef struct packed {
		logic                mul_en;
		ma_t                 mul_a;
		src_t                mul_b;
		op_t                 op;
		src_t                src_a;
		src_t                src_b;
		logic                wr_en;
		src_t                dst;
		jmp_t                jmp;
		logic [UPC_BITS-1:0] target;
		logic                emit;
	} ctl_t;

	localparam ctl_t CTL_NOP = '{
		mul_en: 1'b0, mul_a: MA_ALPHA, mul_b: S_TGT, op: OP_NOP,
		src_a: S_TGT, src_b: S_TGT, wr_en: 1'b0, dst: S_TGT,
		jmp: J_NEXT, target: '0, emit: 1'b0
	};

	function automatic logic signed [31:0] sat_sum(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			return v[32] ? 32'h80000000 : 32'h7fffffff;
		end
		return v[31:0];
	endfunction

	// product rescale, floor rounding, then clamp
	function automatic logic signed [31:0] sat_prod(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p >>> FRAC_BITS;
		if (s > SAT_HI) begin
			return 32'h7fffffff;
		end
		if (s < SAT_LO) begin
			return 32'h80000000;
		end
		return s[31:0];
	endfunction

endpackage

>>> rtl/smc_useq.sv
module smc_useq import smc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic big,
	input  logic blocked,
	output ctl_t ctl,
	output logic busy
);

	localparam logic [UPC_BITS-1:0] L_SAT  = 5'd16;
	localparam logic [UPC_BITS-1:0] L_GAIN = 5'd17;

	function automatic ctl_t ucode(input logic [UPC_BITS-1:0] pc);
		ctl_t w;
		w = CTL_NOP;
		case (pc)
			5'd0: begin
				w.mul_en = 1'b1; w.mul_a = MA_ALPHA; w.mul_b = S_MEAS;
			end
			5'd1: begin
				w.mul_en = 1'b1; w.mul_a = MA_ONEMA; w.mul_b = S_DIST;
				w.op = OP_PASS; w.src_b = S_PROD; w.wr_en = 1'b1; w.dst = S_T0;
			end
			5'd2: begin
				w.op = OP_ADD; w.src_a = S_T0; w.src_b = S_PROD;
				w.wr_en = 1'b1; w.dst = S_DIST;
			end
			5'd3: begin
				w.op = OP_SUB; w.src_a = S_TGT; w.src_b = S_DIST;
				w.wr_en = 1'b1; w.dst = S_ERR;
			end
			5'd4: begin
				w.op = OP_SUB; w.src_a = S_ERR; w.src_b = S_PERR;
				w.wr_en = 1'b1; w.dst = S_TMP;
			end
			5'd5: begin
				w.mul_en = 1'b1; w.mul_a = MA_INVDT; w.mul_b = S_TMP;
				w.op = OP_PASS; w.src_b = S_ERR; w.wr_en = 1'b1; w.dst = S_PERR;
			end
			5'd6: begin
				w.op = OP_PASS; w.src_b = S_PROD; w.wr_en = 1'b1; w.dst = S_TMP;
			end
			5'd7: begin
				w.mul_en = 1'b1; w.mul_a = MA_ALPHA; w.mul_b = S_TMP;
			end
			5'd8: begin
				w.mul_en = 1'b1; w.mul_a = MA_ONEMA; w.mul_b = S_RATE;
				w.op = OP_PASS; w.src_b = S_PROD; w.wr_en = 1'b1; w.dst = S_T0;
			end
			5'd9: begin
				w.op = OP_ADD; w.src_a = S_T0; w.src_b = S_PROD;
				w.wr_en = 1'b1; w.dst = S_RATE;
			end
			5'd10: begin
				w.mul_en = 1'b1; w.mul_a = MA_SLOPE; w.mul_b = S_ERR;
			end
			5'd11: begin
				w.op = OP_ADD; w.src_a = S_RATE; w.src_b = S_PROD;
				w.wr_en = 1'b1; w.dst = S_SURF;
			end
			5'd12: begin
				w.mul_en = 1'b1; w.mul_a = MA_INVPHI; w.mul_b = S_SURF;
			end
			5'd13: begin
				w.op = OP_PREP; w.src_b = S_PROD; w.jmp = J_BIG; w.target = L_SAT;
			end
			5'd14: begin
				w.mul_en = 1'b1; w.mul_a = MA_DIFF; w.mul_b = S_FRAC;
			end
			5'd15: begin
				w.op = OP_INTERP; w.wr_en = 1'b1; w.dst = S_TH;
				w.jmp = J_GO; w.target = L_GAIN;
			end
			5'd16: begin
				w.op = OP_SATONE; w.wr_en = 1'b1; w.dst = S_TH;
			end
			5'd17: begin
				w.mul_en = 1'b1; w.mul_a = MA_GAIN; w.mul_b = S_TH;
			end
			5'd18: begin
				w.op = OP_NEG; w.src_b = S_PROD; w.emit = 1'b1;
			end
			default: begin
				w = CTL_NOP;
			end
		endcase
		return w;
	endfunction

	logic [UPC_BITS-1:0] pc_q;
	logic [UPC_BITS-1:0] pc_next;
	logic                busy_q;
	logic                hold;
	logic                advance;
	ctl_t                word;

	assign word    = ucode(pc_q);
	assign hold    = word.emit & blocked;
	assign advance = busy_q & ~hold;
	assign ctl     = advance ? word : CTL_NOP;
	assign busy    = busy_q;

	always_comb begin
		case (word.jmp)
			J_GO:    pc_next = word.target;
			J_BIG:   pc_next = big ? word.target : pc_q + 5'd1;
			default: pc_next = pc_q + 5'd1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= '0;
		end else if (advance) begin
			if (word.emit) begin
				busy_q <= 1'b0;
				pc_q   <= '0;
			end else begin
				pc_q <= pc_next;
			end
		end
	end

endmodule

>>> rtl/smc_dp.sv
module smc_dp import smc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  in_item_t  item,
	input  cfg_t      cfg,
	input  ctl_t      ctl,
	output logic      big,
	output out_item_t res
);

	localparam logic [63:0] ONE_W = 64'h1 << WIDE_BITS;

	logic signed [31:0] tgt_q, meas_q, dist_q, err_q, perr_q, rate_q;
	logic signed [31:0] surf_q, tmp_q, t0_q, th_q;
	logic signed [63:0] prod_q;
	logic               tsign_q;
	logic [TANH_IDX_BITS-1:0] tidx_q;
	logic [TANH_SHIFT-1:0]    tfrac_q;

	logic signed [31:0] prod_p;
	logic signed [31:0] a_val, b_val, mb_val, ma_val;
	logic signed [31:0] alu_res;
	logic [32:0]        b_ext;
	logic [32:0]        abs_u;

	logic [TANH_IDX_BITS-1:0] idx_nx;
	logic [TANH_BITS-1:0]     y0, y1_raw, y1, diff, mag;
	logic [31:0]              mag_ext;

	wire [TANH_ENTRIES-1:0][TANH_BITS-1:0] tanh_rom;

	// tanh(4k/N) via e^-y, y = 8k/N, worked in Q30 integers into Q16 entries; constant table
	for (genvar k = 0; k < TANH_ENTRIES; k++) begin : g_tanh
		localparam logic [63:0] Y   = (64'(8 * k) << WIDE_BITS) / 64'(TANH_ENTRIES);
		localparam logic [63:0] Z   = Y >> 8;
		localparam logic [63:0] Z2  = (Z * Z) >> WIDE_BITS;
		localparam logic [63:0] Z3  = (Z2 * Z) >> WIDE_BITS;
		localparam logic [63:0] Z4  = (Z3 * Z) >> WIDE_BITS;
		localparam logic [63:0] EX0 = ONE_W - Z + Z2 / 64'd2 - Z3 / 64'd6 + Z4 / 64'd24;
		localparam logic [63:0] EX1 = (EX0 * EX0) >> WIDE_BITS;
		localparam logic [63:0] EX2 = (EX1 * EX1) >> WIDE_BITS;
		localparam logic [63:0] EX3 = (EX2 * EX2) >> WIDE_BITS;
		localparam logic [63:0] EX4 = (EX3 * EX3) >> WIDE_BITS;
		localparam logic [63:0] EX5 = (EX4 * EX4) >> WIDE_BITS;
		localparam logic [63:0] EX6 = (EX5 * EX5) >> WIDE_BITS;
		localparam logic [63:0] EX7 = (EX6 * EX6) >> WIDE_BITS;
		localparam logic [63:0] EX8 = (EX7 * EX7) >> WIDE_BITS;
		localparam logic [63:0] EXC = (EX8 > ONE_W) ? ONE_W : EX8;
		localparam logic [63:0] DEN = ONE_W + EXC;
		localparam logic [63:0] Q   = (((ONE_W - EXC) << FRAC_BITS) + DEN / 64'd2) / DEN;
		assign tanh_rom[k] = Q[TANH_BITS-1:0];
	end

	assign prod_p = sat_prod(prod_q);

	function automatic logic signed [31:0] pick(input src_t s);
		case (s)
			S_TGT:   return tgt_q;
			S_MEAS:  return meas_q;
			S_DIST:  return dist_q;
			S_ERR:   return err_q;
			S_PERR:  return perr_q;
			S_RATE:  return rate_q;
			S_SURF:  return surf_q;
			S_TMP:   return tmp_q;
			S_T0:    return t0_q;
			S_TH:    return th_q;
			S_FRAC:  return 32'(tfrac_q);
			S_PROD:  return prod_p;
			default: return '0;
		endcase
	endfunction

	always_comb begin
		a_val  = pick(ctl.src_a);
		b_val  = pick(ctl.src_b);
		mb_val = pick(ctl.mul_b);
	end

	// tanh segment from the latched index
	assign y0     = tanh_rom[tidx_q];
	assign idx_nx = tidx_q + TANH_IDX_BITS'(1);
	assign y1_raw = (tidx_q == TANH_IDX_BITS'(TANH_ENTRIES - 1)) ?
		TANH_BITS'(FX_ONE) : tanh_rom[idx_nx];
	assign y1      = (y1_raw < y0) ? y0 : y1_raw;
	assign diff    = y1 - y0;
	assign mag     = y0 + TANH_BITS'(prod_q >> TANH_SHIFT);
	assign mag_ext = 32'(mag);

	always_comb begin
		case (ctl.mul_a)
			MA_ALPHA:  ma_val = 32'(cfg.filter_weight);
			MA_ONEMA:  ma_val = FX_ONE - 32'(cfg.filter_weight);
			MA_INVDT:  ma_val = 32'(cfg.inverse_step_time);
			MA_SLOPE:  ma_val = 32'(cfg.surface_slope);
			MA_GAIN:   ma_val = 32'(cfg.drive_gain);
			MA_INVPHI: ma_val = 32'(cfg.inverse_boundary_width);
			MA_DIFF:   ma_val = 32'(diff);
			default:   ma_val = '0;
		endcase
	end

	assign b_ext = {b_val[31], b_val};
	assign abs_u = b_val[31] ? (33'd0 - b_ext) : b_ext;
	assign big   = (abs_u >= TANH_LIMIT);

	always_comb begin
		case (ctl.op)
			OP_ADD:    alu_res = sat_sum({a_val[31], a_val} + b_ext);
			OP_SUB:    alu_res = sat_sum({a_val[31], a_val} - b_ext);
			OP_PASS:   alu_res = b_val;
			OP_NEG:    alu_res = sat_sum(33'sd0 - b_ext);
			OP_INTERP: alu_res = tsign_q ? (32'd0 - mag_ext) : mag_ext;
			OP_SATONE: alu_res = tsign_q ? (32'd0 - FX_ONE) : FX_ONE;
			default:   alu_res = '0;
		endcase
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
			rate_q <= '0;
			perr_q <= '0;
		end else if (ctl.wr_en) begin
			case (ctl.dst)
				S_DIST:  dist_q <= alu_res;
				S_RATE:  rate_q <= alu_res;
				S_PERR:  perr_q <= alu_res;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (load) begin
			tgt_q  <= item.target_value;
			meas_q <= item.measured_value;
		end
		if (ctl.mul_en) begin
			prod_q <= ma_val * mb_val;
		end
		if (ctl.op == OP_PREP) begin
			tsign_q <= b_val[31];
			tidx_q  <= abs_u[TANH_SHIFT +: TANH_IDX_BITS];
			tfrac_q <= abs_u[TANH_SHIFT-1:0];
		end
		if (ctl.wr_en) begin
			case (ctl.dst)
				S_ERR:   err_q  <= alu_res;
				S_SURF:  surf_q <= alu_res;
				S_TMP:   tmp_q  <= alu_res;
				S_T0:    t0_q   <= alu_res;
				S_TH:    th_q   <= alu_res;
				default: ;
			endcase
		end
	end

	assign res.control_drive       = alu_res;
	assign res.filtered_distance   = dist_q;
	assign res.error_value         = err_q;
	assign res.filtered_error_rate = rate_q;
	assign res.sliding_surface     = surf_q;

endmodule

>>> rtl/sliding_mode_controller_step.sv
// sliding mode controller step: one beat in, one result beat out
// the microcode runs 17 steps from input beat to result valid when the tanh input saturates, 18 when it interpolates
// one item in flight: a new input beat waits until the last one ends its microcode on one shared multiplier
// the next input beat is taken while a finished result still waits downstream
// reset: configuration to defaults, filter states and previous error to zero, no result
module sliding_mode_controller_step import smc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  in_item_t                  item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output out_item_t                 result,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [CFG_BITS-1:0]       wr_data
);

	// register defaults: weight about 0.1, 1/dt 100.0, the rest 1.0
	localparam logic [16:0]         RST_FILTER_WEIGHT = 17'd6554;
	localparam logic [CFG_BITS-1:0] RST_INV_STEP_TIME = 31'd6553600;
	localparam logic [CFG_BITS-1:0] RST_UNITY         = 31'd65536;

	cfg_t      cfg_q;
	out_item_t result_q;
	out_item_t dp_res;
	logic      result_valid_q;
	logic      accept;
	logic      busy;
	logic      big;
	logic      blocked;
	ctl_t      ctl;

	// one item in flight; the result register decouples the output side
	assign item_stall = busy;
	assign accept     = item_valid & ~busy;
	assign blocked    = result_valid_q & result_stall;

	// configuration writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_weight          <= RST_FILTER_WEIGHT;
			cfg_q.inverse_step_time      <= RST_INV_STEP_TIME;
			cfg_q.surface_slope          <= RST_UNITY;
			cfg_q.drive_gain             <= RST_UNITY;
			cfg_q.inverse_boundary_width <= RST_UNITY;
		end else if (wr_en) begin
			case (wr_index)
				CFG_FILTER_WEIGHT:   cfg_q.filter_weight          <= wr_data[16:0];
				CFG_INV_STEP_TIME:   cfg_q.inverse_step_time      <= wr_data;
				CFG_SURFACE_SLOPE:   cfg_q.surface_slope          <= wr_data;
				CFG_DRIVE_GAIN:      cfg_q.drive_gain             <= wr_data;
				CFG_INV_BOUND_WIDTH: cfg_q.inverse_boundary_width <= wr_data;
				default: ;
			endcase
		end
	end

	// step counter and control store
	smc_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.big     (big),
		.blocked (blocked),
		.ctl     (ctl),
		.busy    (busy)
	);

	// registers, shared multiplier, saturating adder and tanh interpolation
	smc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.item   (item),
		.cfg    (cfg_q),
		.ctl    (ctl),
		.big    (big),
		.res    (dp_res)
	);

	// result register, loaded on the final microcode step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_valid_q && !result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			result_q <= dp_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> sim/sliding_mode_step_monitor.sv
module sliding_mode_step_monitor import smc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  logic                      item_stall,
	input  in_item_t                  item,
	input  logic                      result_valid,
	input  logic                      result_stall,
	input  out_item_t                 result,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [CFG_BITS-1:0]       wr_data,
	output int                        mismatch_total,
	output int                        pending_count,
	output int                        checked_count
);

	localparam longint          ONE_FX    = longint'(1) << FRAC_BITS;
	localparam longint unsigned WIDE_UNIT = 64'd1 << WIDE_BITS;
	localparam int              POS_BITS  = FRAC_BITS + 2;
	localparam longint          SAT_MAX   = 64'sd2147483647;
	localparam longint          SAT_MIN   = -64'sd2147483648;

	cfg_t               ctl_regs;
	logic signed [31:0] dist_state;
	logic signed [31:0] rate_state;
	logic signed [31:0] err_state;
	longint unsigned    tanh_samples [TANH_ENTRIES];
	out_item_t          predicted_steps [$];
	out_item_t          next_step;
	out_item_t          oldest_step;

	// tanh(4k/N) through e^-(y/256) squared eight times, worked in Q30, stored in Q16
	initial begin
		longint unsigned y, z, z2, z3, z4, t, den;
		for (int k = 0; k < TANH_ENTRIES; k++) begin
			y  = ((64'd8 * k) << WIDE_BITS) / TANH_ENTRIES;
			z  = y >> 8;
			z2 = (z * z) >> WIDE_BITS;
			z3 = (z2 * z) >> WIDE_BITS;
			z4 = (z3 * z) >> WIDE_BITS;
			t  = WIDE_UNIT - z + z2 / 2 - z3 / 6 + z4 / 24;
			for (int i = 0; i < 8; i++) begin
				t = (t * t) >> WIDE_BITS;
			end
			if (t > WIDE_UNIT) begin
				t = WIDE_UNIT;
			end
			den = WIDE_UNIT + t;
			tanh_samples[k] = (((WIDE_UNIT - t) << FRAC_BITS) + den / 2) / den;
		end
	end

	function automatic longint clamp32(input longint v);
		if (v > SAT_MAX) begin
			return SAT_MAX;
		end
		if (v < SAT_MIN) begin
			return SAT_MIN;
		end
		return v;
	endfunction

	// floor rescale of the exact product
	function automatic longint fx_product(input longint a, input longint b);
		longint p;
		p = a * b;
		return clamp32(p >>> FRAC_BITS);
	endfunction

	function automatic longint smooth(input longint x, input longint prev);
		longint alpha;
		alpha = longint'(ctl_regs.filter_weight);
		return clamp32(fx_product(alpha, x) + fx_product(ONE_FX - alpha, prev));
	endfunction

	function automatic longint tanh_eval(input longint u);
		longint unsigned mag, pos, idx, frac, y0, y1, r;
		mag = (u < 0) ? -u : u;
		if (mag >= (64'd4 << FRAC_BITS)) begin
			r = ONE_FX;
		end else begin
			pos  = mag * TANH_ENTRIES;
			idx  = pos >> POS_BITS;
			frac = pos & ((64'd1 << POS_BITS) - 1);
			if (idx >= TANH_ENTRIES) begin
				idx = TANH_ENTRIES - 1;
			end
			y0 = tanh_samples[idx];
			y1 = (idx + 1 < TANH_ENTRIES) ? tanh_samples[idx + 1] : ONE_FX;
			if (y1 < y0) begin
				y1 = y0;
			end
			r = y0 + (((y1 - y0) * frac) >> POS_BITS);
		end
		return (u < 0) ? -longint'(r) : longint'(r);
	endfunction

	task automatic advance_controller(input in_item_t s, output out_item_t r);
		longint filt_dist, err, raw_rate, rate, surf, squashed, drive;
		filt_dist = smooth(longint'(s.measured_value), longint'(dist_state));
		err       = clamp32(longint'(s.target_value) - filt_dist);
		raw_rate  = fx_product(clamp32(err - longint'(err_state)),
			longint'(ctl_regs.inverse_step_time));
		rate      = smooth(raw_rate, longint'(rate_state));
		surf      = clamp32(rate + fx_product(longint'(ctl_regs.surface_slope), err));
		squashed  = tanh_eval(fx_product(surf, longint'(ctl_regs.inverse_boundary_width)));
		drive     = clamp32(-fx_product(longint'(ctl_regs.drive_gain), squashed));
		dist_state = filt_dist[31:0];
		rate_state = rate[31:0];
		err_state  = err[31:0];
		r.control_drive       = drive[31:0];
		r.filtered_distance   = filt_dist[31:0];
		r.error_value         = err[31:0];
		r.filtered_error_rate = rate[31:0];
		r.sliding_surface     = surf[31:0];
	endtask

	task automatic note_register_write(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_BITS-1:0] data);
		case (idx)
			CFG_FILTER_WEIGHT:   ctl_regs.filter_weight          = data[16:0];
			CFG_INV_STEP_TIME:   ctl_regs.inverse_step_time      = data;
			CFG_SURFACE_SLOPE:   ctl_regs.surface_slope          = data;
			CFG_DRIVE_GAIN:      ctl_regs.drive_gain             = data;
			CFG_INV_BOUND_WIDTH: ctl_regs.inverse_boundary_width = data;
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_total++;
		$display("mismatch at %0t, result beat %0d: %s", $realtime, checked_count, msg);
	endtask

	task automatic check_field(input string name, input logic signed [31:0] got,
		input logic signed [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_regs = '{filter_weight: 17'd6554, inverse_step_time: 31'd6553600,
				surface_slope: 31'd65536, drive_gain: 31'd65536,
				inverse_boundary_width: 31'd65536};
			dist_state = '0;
			rate_state = '0;
			err_state  = '0;
			predicted_steps.delete();
			pending_count <= 0;
		end else begin
			if (wr_en) begin
				note_register_write(wr_index, wr_data);
			end
			if (result_valid && !result_stall) begin
				if (predicted_steps.size() == 0) begin
					report_mismatch("result beat with nothing pending");
				end else begin
					oldest_step = predicted_steps.pop_front();
					check_field("control_drive", result.control_drive,
						oldest_step.control_drive);
					check_field("filtered_distance", result.filtered_distance,
						oldest_step.filtered_distance);
					check_field("error_value", result.error_value, oldest_step.error_value);
					check_field("filtered_error_rate", result.filtered_error_rate,
						oldest_step.filtered_error_rate);
					check_field("sliding_surface", result.sliding_surface,
						oldest_step.sliding_surface);
				end
				checked_count++;
			end
			if (item_valid && !item_stall) begin
				advance_controller(item, next_step);
				predicted_steps.push_back(next_step);
			end
			pending_count <= predicted_steps.size();
		end
	end

endmodule

>>> sim/sliding_mode_controller_step_tb.sv
module sliding_mode_controller_step_tb;
	import smc_pkg::*;

	// overall run guard, several times the slowest expected run
	localparam int RUN_LIMIT = 9_000_000;
	// small operating range for well-behaved trajectories, plus or minus 6.0
	localparam int SMALL_SPAN = 6 << 16;
	// hold-off length of the receiver when asked for one
	localparam int HOLD_CYCLES = 400;
	// first register index that decodes to nothing
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_FIRST = 3'd5;

	typedef enum int {MIX_FULL, MIX_SMALL, MIX_TRACK, MIX_CORNER} mix_t;
	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      item_valid   = 1'b0;
	logic                      item_stall;
	in_item_t                  item         = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	out_item_t                 result;
	logic                      wr_en        = 1'b0;
	logic [CFG_INDEX_BITS-1:0] wr_index     = '0;
	logic [CFG_BITS-1:0]       wr_data      = '0;

	int mismatches;
	int pending;
	int results_checked;

	int samples_sent   = 0;
	int settings_used  = 1;
	int hold_requests  = 0;
	logic signed [31:0] track_target = '0;

	always #6 clk = ~clk;

	sliding_mode_controller_step uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	// watches both channels and the register port, predicts every result beat
	sliding_mode_step_monitor watch (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.mismatch_total (mismatches),
		.pending_count  (pending),
		.checked_count  (results_checked)
	);

	// receiver side: a stall pattern that changes every so often, and a long
	// hold-off whenever the stimulus asks for one
	int       hold_served  = 0;
	int       hold_left    = 0;
	rx_mode_t rx_mode      = RX_FREE;
	int       rx_mode_left = 0;
	int       rx_period    = 3;
	int       rx_phase     = 0;

	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (rx_mode_left == 0) begin
			rx_mode      = rx_mode_t'($urandom_range(0, 3));
			rx_mode_left = $urandom_range(10, 300);
			rx_period    = $urandom_range(2, 7);
		end else begin
			rx_mode_left--;
		end
		rx_phase++;
		if (hold_left > 0) begin
			// long hold-off, counted here so the sender keeps pushing
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			case (rx_mode)
				RX_FREE:     result_stall <= 1'b0;
				RX_LIGHT:    result_stall <= ($urandom_range(0, 9) < 3);
				RX_HEAVY:    result_stall <= ($urandom_range(0, 9) < 8);
				default:     result_stall <= ((rx_phase % rx_period) == 0);
			endcase
		end
	end

	// one beat on the sample channel; returns at the edge that took it
	task automatic push_sample(input in_item_t s);
		item       <= s;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		samples_sent++;
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// sender stops until every pending result beat is out, then lets the
	// pipeline run dry
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_BITS-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
	endtask

	// every register, then a write to an index that decodes to nothing,
	// last so a wrong decode would overwrite a live register
	task automatic load_settings(input logic [CFG_BITS-1:0] alpha,
		input logic [CFG_BITS-1:0] inv_dt, input logic [CFG_BITS-1:0] slope,
		input logic [CFG_BITS-1:0] gain, input logic [CFG_BITS-1:0] inv_phi);
		write_reg(CFG_FILTER_WEIGHT, alpha);
		write_reg(CFG_INV_STEP_TIME, inv_dt);
		write_reg(CFG_SURFACE_SLOPE, slope);
		write_reg(CFG_DRIVE_GAIN, gain);
		write_reg(CFG_INV_BOUND_WIDTH, inv_phi);
		write_reg(CFG_UNUSED_FIRST + CFG_INDEX_BITS'($urandom_range(0, 2)),
			CFG_BITS'($urandom));
		wr_en <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// mostly a moderate value, now and then any 31-bit pattern
	function automatic logic [CFG_BITS-1:0] pick_reg(input int unsigned span);
		if ($urandom_range(0, 4) == 0) begin
			return CFG_BITS'($urandom);
		end
		return CFG_BITS'($urandom_range(0, span));
	endfunction

	task automatic load_random_settings();
		logic [CFG_BITS-1:0] alpha;
		// weight mostly within one, sometimes above it
		if ($urandom_range(0, 5) == 0) begin
			alpha = CFG_BITS'($urandom_range(65537, 131071));
		end else begin
			alpha = CFG_BITS'($urandom_range(0, 65536));
		end
		load_settings(alpha, pick_reg(200 << 16), pick_reg(8 << 16), pick_reg(20 << 16),
			pick_reg(4 << 16));
	endtask

	function automatic logic signed [31:0] small_word();
		return int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
	endfunction

	function automatic logic signed [31:0] corner_word();
		case ($urandom_range(0, 5))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return 32'sh0;
			3:       return -32'sd1;
			4:       return 32'sd1;
			default: return 32'sh00010000;
		endcase
	endfunction

	function automatic mix_t pick_mix();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			return MIX_FULL;
		end
		if (r < 45) begin
			return MIX_SMALL;
		end
		if (r < 90) begin
			return MIX_TRACK;
		end
		return MIX_CORNER;
	endfunction

	// sender gaps: none, short, medium or long idle stretches
	function automatic int pick_gap();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return $urandom_range(1, 3);
			2:       return $urandom_range(4, 20);
			default: return $urandom_range(20, 60);
		endcase
	endfunction

	task automatic make_sample(input mix_t mix, output in_item_t s);
		case (mix)
			MIX_FULL: begin
				s.target_value   = $urandom;
				s.measured_value = $urandom;
			end
			MIX_SMALL: begin
				s.target_value   = small_word();
				s.measured_value = small_word();
			end
			MIX_TRACK: begin
				// a set point that steps now and then, measurement close behind
				if ($urandom_range(0, 19) == 0) begin
					track_target = small_word();
				end
				s.target_value   = track_target;
				s.measured_value = track_target + (int'($urandom_range(0, 32768)) - 16384);
			end
			default: begin
				s.target_value   = corner_word();
				s.measured_value = corner_word();
			end
		endcase
	endtask

	task automatic run_random(input int count, input bit gapless);
		int       left;
		int       burst;
		mix_t     mix;
		in_item_t s;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			if (burst > left) begin
				burst = left;
			end
			mix = pick_mix();
			repeat (burst) begin
				make_sample(mix, s);
				push_sample(s);
			end
			left -= burst;
			if (!gapless) begin
				idle_for(pick_gap());
			end
		end
	endtask

	// field extremes, unit steps and the edge of the tanh table
	task automatic run_directed();
		push_sample('{32'sh0, 32'sh0});
		push_sample('{32'sh7fffffff, 32'sh80000000});
		push_sample('{32'sh80000000, 32'sh7fffffff});
		push_sample('{32'sh7fffffff, 32'sh7fffffff});
		push_sample('{32'sh80000000, 32'sh80000000});
		push_sample('{32'sh0, -32'sd1});
		push_sample('{-32'sd1, 32'sh0});
		push_sample('{32'sd1, 32'sd1});
		push_sample('{32'sh00010000, 32'sh0});
		push_sample('{-32'sh00010000, 32'sh0});
		push_sample('{32'sh00040000, 32'sh0});
		push_sample('{32'sh0, 32'sh00040000});
		push_sample('{32'sh0003ffff, 32'sh0});
		push_sample('{32'sh7fffffff, 32'sh0});
		push_sample('{32'sh0, 32'sh80000000});
		push_sample('{32'sh0, 32'sh0});
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of every register
		run_directed();
		run_random(120, 1'b0);
		settle();

		// every register at zero: filters hold their state, no new rate input, no drive
		load_settings('0, '0, '0, '0, '0);
		run_directed();
		run_random(100, 1'b0);
		settle();

		// weight exactly one, every other register at its top
		load_settings(CFG_BITS'(FX_ONE), '1, '1, '1, '1);
		run_directed();
		run_random(100, 1'b0);
		settle();

		// overfull weight word: bits above the field drop, weight above one
		load_settings('1, CFG_BITS'(32'd6553600), CFG_BITS'(32'd65536),
			CFG_BITS'(32'd65536), CFG_BITS'(32'd65536));
		run_random(100, 1'b0);
		settle();

		// receiver holds off for a long stretch while beats keep coming, so the
		// block fills and stalls its input; then a pause until all is out
		load_random_settings();
		hold_requests++;
		run_random(80, 1'b1);
		settle();
		run_random(40, 1'b0);
		settle();

		for (int p = 0; p < 8; p++) begin
			load_random_settings();
			if (p == 5) begin
				hold_requests++;
			end
			run_random(140, (p == 2) || (p == 5));
			settle();
		end

		$display("covered %0d samples over %0d register settings with %0d long hold-offs",
			samples_sent, settings_used, hold_requests);
		$display("%0d result beats compared field by field", results_checked);
		if (mismatches == 0) begin
			$display("PASS sliding_mode_controller_step");
		end else begin
			$display("FAIL sliding_mode_controller_step");
		end
		$finish;
	end

	// guard against a hung handshake or results that never come
	initial begin
		#(RUN_LIMIT);
		$display("FAIL sliding_mode_controller_step");
		$finish;
	end

endmodule
